// ===== src/jpp_pkg.sv =====
// Shared types and constants for the JSON layout engine.
// No dependencies; imported by the controller, the datapath and the top level.
package jpp_pkg;

    localparam int unsigned MAX_INDENT = 62;
    localparam int unsigned LVL_W      = 6;
    localparam int unsigned STEP_W     = 4;
    localparam int unsigned BYTE_W     = 8;

    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

    // Configuration register indexes
    localparam logic REG_LAYOUT_MODE = 1'b0;
    localparam logic REG_INDENT_STEP = 1'b1;

    typedef enum logic [2:0] {
        K_DROP,
        K_SINGLE,
        K_OPEN,
        K_CLOSE,
        K_COMMA,
        K_COLON
    } t_kind;

    typedef enum logic [1:0] {
        EMIT_CHAR,
        EMIT_NL,
        EMIT_SPACE
    } t_emit_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_SECOND,
        S_SPACES,
        S_TAIL
    } t_state;

    typedef struct packed {
        logic      accept;
        logic      emit;
        t_emit_sel sel;
        logic      last;
        logic      dec_count;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  cnt_zero;
        logic  cnt_one;
        logic  can_load;
    } t_status;

endpackage

// ===== src/jpp_ctrl.sv =====
// Sequencer for the layout engine: walks the output run of each accepted byte.
// Depends on jpp_pkg; drives the datapath by t_cmd and reads t_status.
module jpp_ctrl import jpp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.accept    = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.sel       = EMIT_CHAR;
        o_cmd.last      = 1'b0;
        o_cmd.dec_count = 1'b0;
        o_in_stall      = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_FIRST;
                end
            end
            S_FIRST: begin
                // a dropped byte leaves nothing to emit
                if (i_status.kind == K_DROP) begin
                    n_state = S_IDLE;
                end else if (i_status.can_load) begin
                    o_cmd.emit = 1'b1;
                    case (i_status.kind)
                        K_SINGLE: begin
                            o_cmd.last = 1'b1;
                            n_state    = S_IDLE;
                        end
                        K_CLOSE: begin
                            o_cmd.sel = EMIT_NL;
                            n_state   = i_status.cnt_zero ? S_TAIL : S_SPACES;
                        end
                        default: begin
                            n_state = S_SECOND;
                        end
                    endcase
                end
            end
            S_SECOND: begin
                if (i_status.can_load) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.kind == K_COLON) begin
                        o_cmd.sel  = EMIT_SPACE;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.sel  = EMIT_NL;
                        o_cmd.last = i_status.cnt_zero;
                        n_state    = i_status.cnt_zero ? S_IDLE : S_SPACES;
                    end
                end
            end
            S_SPACES: begin
                if (i_status.can_load) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.sel       = EMIT_SPACE;
                    o_cmd.dec_count = 1'b1;
                    o_cmd.last      = i_status.cnt_one && (i_status.kind != K_CLOSE);
                    if (i_status.cnt_one) begin
                        n_state = (i_status.kind == K_CLOSE) ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL: begin
                if (i_status.can_load) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/jpp_dp.sv =====
// Datapath of the layout engine: byte classifier, string and indent state,
// configuration registers, space counter and output register. Depends on jpp_pkg.
module jpp_dp import jpp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [STEP_W-1:0] i_cfg_data,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_last_of_run
);

    logic              r_layout_mode;
    logic [STEP_W-1:0] r_indent_step;
    logic              r_inside_string;
    logic              r_escape_pending;
    logic [LVL_W-1:0]  r_indent_level;
    logic [BYTE_W-1:0] r_byte;
    t_kind             r_kind;
    logic [LVL_W-1:0]  r_count;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic              n_inside_string;
    logic              n_escape_pending;
    logic [LVL_W-1:0]  n_indent_level;
    logic [LVL_W-1:0]  n_count;
    t_kind             n_kind;
    logic [LVL_W:0]    w_sum;
    logic [LVL_W-1:0]  w_open_lvl;
    logic [LVL_W-1:0]  w_close_lvl;
    logic              w_blank;
    logic [BYTE_W-1:0] w_emit_byte;

    assign w_sum      = {1'b0, r_indent_level} + {{(LVL_W + 1 - STEP_W){1'b0}}, r_indent_step};
    assign w_open_lvl = (w_sum > (LVL_W + 1)'(MAX_INDENT)) ? LVL_W'(MAX_INDENT)
                                                          : w_sum[LVL_W-1:0];
    assign w_close_lvl = (r_indent_level > {{(LVL_W - STEP_W){1'b0}}, r_indent_step})
                       ? r_indent_level - {{(LVL_W - STEP_W){1'b0}}, r_indent_step}
                       : '0;
    assign w_blank = (i_in_byte == CH_SPACE) || (i_in_byte == CH_TAB) ||
                     (i_in_byte == CH_LF) || (i_in_byte == CH_CR);

    // Classify the incoming byte and work out the state it leaves behind
    always_comb begin
        n_inside_string  = r_inside_string;
        n_escape_pending = r_escape_pending;
        n_indent_level   = r_indent_level;
        n_count          = '0;
        n_kind           = K_SINGLE;
        if (r_escape_pending) begin
            n_escape_pending = 1'b0;
        end else if (r_inside_string && (i_in_byte == CH_BSLASH)) begin
            n_escape_pending = 1'b1;
        end else if (i_in_byte == CH_QUOTE) begin
            n_inside_string = !r_inside_string;
        end else if (r_inside_string) begin
            n_kind = K_SINGLE;
        end else if (w_blank) begin
            n_kind = K_DROP;
        end else if (r_layout_mode) begin
            n_kind = K_SINGLE;
        end else if ((i_in_byte == CH_LBRACE) || (i_in_byte == CH_LBRACK)) begin
            n_kind         = K_OPEN;
            n_indent_level = w_open_lvl;
            n_count        = w_open_lvl;
        end else if ((i_in_byte == CH_RBRACE) || (i_in_byte == CH_RBRACK)) begin
            n_kind         = K_CLOSE;
            n_indent_level = w_close_lvl;
            n_count        = w_close_lvl;
        end else if (i_in_byte == CH_COMMA) begin
            n_kind  = K_COMMA;
            n_count = r_indent_level;
        end else if (i_in_byte == CH_COLON) begin
            n_kind = K_COLON;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout_mode    <= 1'b0;
            r_indent_step    <= STEP_W'(2);
            r_inside_string  <= 1'b0;
            r_escape_pending <= 1'b0;
            r_indent_level   <= '0;
            r_kind           <= K_DROP;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LAYOUT_MODE: r_layout_mode <= i_cfg_data[0];
                    REG_INDENT_STEP: r_indent_step <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_inside_string  <= n_inside_string;
                r_escape_pending <= n_escape_pending;
                r_indent_level   <= n_indent_level;
                r_kind           <= n_kind;
            end
        end
    end

    // Hold the byte and the space count of the run in progress
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte  <= i_in_byte;
            r_count <= n_count;
        end else if (i_cmd.dec_count) begin
            r_count <= r_count - LVL_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.sel)
            EMIT_NL:    w_emit_byte = CH_LF;
            EMIT_SPACE: w_emit_byte = CH_SPACE;
            default:    w_emit_byte = r_byte;
        endcase
    end

    // Output register: load while empty or while the current transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= w_emit_byte;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_status.kind     = r_kind;
    assign o_status.cnt_zero = (r_count == '0);
    assign o_status.cnt_one  = (r_count == LVL_W'(1));
    assign o_status.can_load = !r_out_valid || !i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_out_last_of_run = r_out_last;

endmodule

// ===== src/json_pretty_printer_top.sv =====
// JSON layout engine: pretty-print or minify a byte stream, one byte per transaction.
// Each accepted input byte emits a run of 1 to 64 bytes, or none for dropped whitespace;
// the input stalls until the run's last byte is loaded, so a new byte is taken only after the last one;
// the run goes into the output register one byte per cycle while the output is not stalled.
// Reset (synchronous, active low) clears string, escape and indent state and loads
// minify off and an indent step of two; no clearing pass is needed.
module json_pretty_printer_top import jpp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_last_of_run,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [STEP_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    jpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    jpp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_byte         (i_in_byte),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_byte        (o_out_byte),
        .o_out_last_of_run (o_out_last_of_run)
    );

endmodule

// ===== test/tb.sv =====
// Self-checking bench for json_pretty_printer_top: layout predictor, scoreboard and stimulus.
// Depends on jpp_pkg for byte constants and register indexes; needs only the RTL in src/.
import jpp_pkg::*;

typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
} t_layout_byte;

class layout_scoreboard;
    logic              minify;
    logic [STEP_W-1:0] step;
    logic              in_str;
    logic              esc;
    logic [LVL_W-1:0]  level;
    t_layout_byte      due[$];

    function new();
        minify = 1'b0;
        step   = 4'd2;
        in_str = 1'b0;
        esc    = 1'b0;
        level  = '0;
    endfunction

    function void set_reg(logic idx, logic [STEP_W-1:0] val);
        if (idx == REG_LAYOUT_MODE) begin
            minify = val[0];
        end else begin
            step = val;
        end
    endfunction

    function int unsigned pending();
        return due.size();
    endfunction

    // Expand one accepted input byte into the run of bytes it should produce.
    function void note_input(logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] run[$];
        int unsigned       lvl;
        if (esc) begin
            esc = 1'b0;
            run.push_back(c);
        end else if (in_str && c == CH_BSLASH) begin
            esc = 1'b1;
            run.push_back(c);
        end else if (c == CH_QUOTE) begin
            in_str = !in_str;
            run.push_back(c);
        end else if (in_str) begin
            run.push_back(c);
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
            // drop whitespace between tokens
        end else if (minify) begin
            run.push_back(c);
        end else if (c == CH_LBRACE || c == CH_LBRACK) begin
            run.push_back(c);
            run.push_back(CH_LF);
            lvl = level + step;
            if (lvl > MAX_INDENT) begin
                lvl = MAX_INDENT;
            end
            level = lvl[LVL_W-1:0];
            repeat (lvl) run.push_back(CH_SPACE);
        end else if (c == CH_RBRACE || c == CH_RBRACK) begin
            run.push_back(CH_LF);
            lvl = (level > step) ? level - step : 0;
            level = lvl[LVL_W-1:0];
            repeat (lvl) run.push_back(CH_SPACE);
            run.push_back(c);
        end else if (c == CH_COMMA) begin
            run.push_back(c);
            run.push_back(CH_LF);
            repeat (level) run.push_back(CH_SPACE);
        end else if (c == CH_COLON) begin
            run.push_back(c);
            run.push_back(CH_SPACE);
        end else begin
            run.push_back(c);
        end
        foreach (run[i]) begin
            due.push_back('{data: run[i], last: (i == run.size() - 1)});
        end
    endfunction

    // Empty string when the byte matches the oldest expectation.
    function string check_result(logic [BYTE_W-1:0] b, logic last);
        t_layout_byte want;
        if (due.size() == 0) begin
            return $sformatf("unexpected output byte %h last %b", b, last);
        end
        want = due.pop_front();
        if (b !== want.data || last !== want.last) begin
            return $sformatf("output byte %h last %b, expected byte %h last %b",
                             b, last, want.data, want.last);
        end
        return "";
    endfunction
endclass

module tb;
    // Slowest correct run: ~470 items, each emitting 64 bytes under the longest output stalls and input gaps.
    localparam int unsigned LIMIT         = 2_000_000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned PHASE_ITEMS   = 55;

    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              i_in_valid        = 1'b0;
    logic [BYTE_W-1:0] i_in_byte         = '0;
    logic              i_out_stall       = 1'b0;
    logic              i_cfg_we          = 1'b0;
    logic              i_cfg_index       = REG_LAYOUT_MODE;
    logic [STEP_W-1:0] i_cfg_data        = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_out_last_of_run;

    layout_scoreboard  sb = new();
    int unsigned       mismatches  = 0;
    int unsigned       cycle_count = 0;
    bit                quiet       = 1'b0;
    logic [BYTE_W-1:0] opening_text [26];

    json_pretty_printer_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_byte         (i_in_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_byte        (o_out_byte),
        .o_out_last_of_run (o_out_last_of_run),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= 200) begin
            $display("cycle %0d: %s", cycle_count, what);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            msg = sb.check_result(o_out_byte, o_out_last_of_run);
            if (msg != "") begin
                report(msg);
            end
        end
    end

    // Back-pressure on the output side in random bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic idle_in(input int unsigned n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        i_in_byte  <= BYTE_W'($urandom_range(0, 255));
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Present one byte and hold it until the transaction completes.
    task automatic feed(input logic [BYTE_W-1:0] b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            idle_in($urandom_range(1, 13));
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(b);
    endtask

    // Hold off input until every expected byte has drained, then let dropped bytes retire.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [STEP_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic run_phase(input logic mode, input logic [STEP_W-1:0] step,
                             input int unsigned items);
        logic [BYTE_W-1:0] tok[$];
        logic [BYTE_W-1:0] b;
        int unsigned       sent;
        int unsigned       pick;
        settle();
        write_reg(REG_LAYOUT_MODE, {3'b000, mode});
        write_reg(REG_INDENT_STEP, step);
        sent = 0;
        while (sent < items) begin
            tok.delete();
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                tok.push_back($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK);
            end else if (pick < 28) begin
                tok.push_back($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK);
            end else if (pick < 40) begin
                tok.push_back(CH_COMMA);
            end else if (pick < 48) begin
                tok.push_back(CH_COLON);
            end else if (pick < 70) begin
                tok.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 6)) begin
                    b = BYTE_W'($urandom_range(0, 255));
                    if (b == CH_QUOTE || b == CH_BSLASH || $urandom_range(0, 4) == 0) begin
                        tok.push_back(CH_BSLASH);
                        tok.push_back($urandom_range(0, 2) == 0 ? CH_QUOTE : b);
                    end else begin
                        tok.push_back(b);
                    end
                end
                // now and then leave the string open
                if ($urandom_range(0, 9) != 0) begin
                    tok.push_back(CH_QUOTE);
                end
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 4)) begin
                    b = $urandom_range(0, 1) ? BYTE_W'($urandom_range(8'h30, 8'h39))
                                             : BYTE_W'($urandom_range(8'h61, 8'h7A));
                    tok.push_back(b);
                end
            end else if (pick < 92) begin
                case ($urandom_range(0, 3))
                    0: tok.push_back(CH_SPACE);
                    1: tok.push_back(CH_TAB);
                    2: tok.push_back(CH_LF);
                    default: tok.push_back(CH_CR);
                endcase
            end else begin
                b = BYTE_W'($urandom_range(0, 255));
                tok.push_back(b);
            end
            foreach (tok[i]) begin
                feed(tok[i]);
                sent++;
                if (sent == items / 2) begin
                    settle();
                end
            end
        end
    endtask

    initial begin
        // Deep nesting to saturate, escaped quote, dropped whitespace, closes past zero
        opening_text = '{CH_LBRACE, CH_LBRACK, CH_LBRACE, CH_LBRACK, CH_LBRACE,
                         CH_QUOTE, CH_BSLASH, CH_QUOTE, CH_LBRACE, CH_SPACE, CH_QUOTE,
                         CH_COLON, CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_BSLASH, CH_COMMA,
                         8'h00, 8'hFF, CH_RBRACE, CH_RBRACK, CH_RBRACE, CH_RBRACK,
                         CH_RBRACE, CH_RBRACK};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_INDENT_STEP, 4'd15);
        foreach (opening_text[i]) begin
            feed(opening_text[i]);
        end

        run_phase(1'b0, 4'd2, PHASE_ITEMS);
        run_phase(1'b0, 4'd0, PHASE_ITEMS);
        run_phase(1'b1, 4'd5, PHASE_ITEMS);
        run_phase(1'b0, 4'd8, PHASE_ITEMS);
        run_phase(1'b0, 4'($urandom_range(9, 15)), PHASE_ITEMS);
        run_phase(1'b1, 4'd0, PHASE_ITEMS);
        run_phase(1'b0, 4'($urandom_range(0, 8)), PHASE_ITEMS);
        settle();
        quiet = 1'b1;
        run_phase(1'b0, 4'd1, PHASE_ITEMS);
        settle();

        if (sb.pending() != 0) begin
            report($sformatf("%0d expected bytes never arrived", sb.pending()));
        end
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
